/* sv/faq_pkg.sv */
// Shared types and constants for the fall alarm qualifier.
// Holds the event codes, the result record and the register reset values.
// No dependencies.
package faq_pkg;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_ALARM   = 3'd1,
        EV_CANCEL  = 3'd2,
        EV_DISARM  = 3'd3,
        EV_ARM     = 3'd4
    } faq_event_t;

    typedef enum logic [2:0] {
        REG_FALL_TH      = 3'd0,
        REG_POST_FALL_TH = 3'd1,
        REG_IMMOBILE_LIM = 3'd2,
        REG_RECOVERY_LIM = 3'd3,
        REG_RECENT_LIM   = 3'd4,
        REG_IMPACT_MASK  = 3'd5
    } faq_reg_t;

    typedef struct packed {
        faq_event_t  event_res;
        logic        threshold_write;
        logic [7:0]  threshold_value;
        logic        armed;
        logic        immobile;
        logic        last;
    } faq_res_t;

    localparam logic [7:0]  FALL_TH_RST      = 8'h0C;
    localparam logic [7:0]  POST_FALL_TH_RST = 8'h03;
    localparam logic [31:0] IMMOBILE_LIM_RST = 32'd10000;
    localparam logic [31:0] RECOVERY_LIM_RST = 32'd40000;
    localparam logic [31:0] RECENT_LIM_RST   = 32'd5000;
    localparam logic [7:0]  IMPACT_MASK_RST  = 8'h07;

endpackage

/* sv/fall_alarm_qualifier.sv */
// Fall alarm qualifier: an accepted request passes through the input register and then the result
// queue before its first result reaches the output ports; a second result follows it from the queue.
// Throughput is one request per cycle while each request gives at most one result; the
// four-entry result queue stalls the input when it lacks room for two results.
// Reset clears the arming state, the motion and impact times and the result queue, and
// loads the register defaults. Depends on faq_pkg.
module fall_alarm_qualifier
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [31:0] now_ms,
    input  logic        irq_pending,
    input  logic [7:0]  sensor_status,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_res,
    output logic        threshold_write,
    output logic [7:0]  threshold_value,
    output logic        armed,
    output logic        immobile,
    output logic        last
);

    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);

    // configuration registers
    logic [7:0]  fall_th_reg;
    logic [7:0]  post_fall_th_reg;
    logic [31:0] immobile_lim_reg;
    logic [31:0] recovery_lim_reg;
    logic [31:0] recent_lim_reg;
    logic [7:0]  impact_mask_reg;

    // block state
    logic        armed_reg;
    logic        immobile_reg;
    logic [31:0] motion_time_reg;
    logic [31:0] first_impact_reg;
    logic        armed_next;
    logic        immobile_next;
    logic [31:0] motion_time_next;
    logic [31:0] first_impact_next;

    // input register
    logic        req_vld_reg;
    logic        cmd_reg;
    logic [31:0] now_reg;
    logic        irq_reg;
    logic [7:0]  status_reg;

    // result queue
    faq_pkg::faq_res_t q_reg [QDEPTH];
    logic [QPW-1:0]    wr_ptr_reg;
    logic [QPW-1:0]    rd_ptr_reg;
    logic [QPW:0]      count_reg;

    faq_pkg::faq_res_t res_a;
    faq_pkg::faq_res_t res_b;
    logic              res_a_vld;
    logic              res_b_vld;
    logic              push;
    logic              pop;
    logic              in_take;
    logic              cfg_wr;
    logic [QPW:0]      push_n;
    faq_pkg::faq_reg_t cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = faq_pkg::faq_reg_t'(paddr[4:2]);

    always_comb
    begin
        unique case (cfg_sel)
            faq_pkg::REG_FALL_TH:      prdata = {24'd0, fall_th_reg};
            faq_pkg::REG_POST_FALL_TH: prdata = {24'd0, post_fall_th_reg};
            faq_pkg::REG_IMMOBILE_LIM: prdata = immobile_lim_reg;
            faq_pkg::REG_RECOVERY_LIM: prdata = recovery_lim_reg;
            faq_pkg::REG_RECENT_LIM:   prdata = recent_lim_reg;
            faq_pkg::REG_IMPACT_MASK:  prdata = {24'd0, impact_mask_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fall_th_reg      <= faq_pkg::FALL_TH_RST;
            post_fall_th_reg <= faq_pkg::POST_FALL_TH_RST;
            immobile_lim_reg <= faq_pkg::IMMOBILE_LIM_RST;
            recovery_lim_reg <= faq_pkg::RECOVERY_LIM_RST;
            recent_lim_reg   <= faq_pkg::RECENT_LIM_RST;
            impact_mask_reg  <= faq_pkg::IMPACT_MASK_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                faq_pkg::REG_FALL_TH:      fall_th_reg      <= pwdata[7:0];
                faq_pkg::REG_POST_FALL_TH: post_fall_th_reg <= pwdata[7:0];
                faq_pkg::REG_IMMOBILE_LIM: immobile_lim_reg <= pwdata;
                faq_pkg::REG_RECOVERY_LIM: recovery_lim_reg <= pwdata;
                faq_pkg::REG_RECENT_LIM:   recent_lim_reg   <= pwdata;
                faq_pkg::REG_IMPACT_MASK:  impact_mask_reg  <= pwdata[7:0];
                default:                   ;
            endcase
        end
    end

    // hold the request until the queue has room for two results
    assign push     = req_vld_reg && (count_reg <= (QPW+1)'(QDEPTH - 2));
    assign in_stall = req_vld_reg && !push;
    assign in_take  = in_valid && !in_stall;
    assign pop      = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_vld_reg <= 1'b0;
        else if (in_take)
            req_vld_reg <= 1'b1;
        else if (push)
            req_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg    <= command;
            now_reg    <= now_ms;
            irq_reg    <= irq_pending;
            status_reg <= sensor_status;
        end
    end

    always_comb
    begin
        logic [31:0] still;
        logic [31:0] since_first;
        logic        impact;
        logic        a1;
        logic        i1;

        still       = now_reg - motion_time_reg;
        since_first = now_reg - first_impact_reg;
        impact      = irq_reg && ((status_reg & impact_mask_reg) != 8'd0);
        a1          = armed_reg;
        i1          = immobile_reg;

        armed_next        = armed_reg;
        immobile_next     = immobile_reg;
        motion_time_next  = motion_time_reg;
        first_impact_next = first_impact_reg;
        res_a_vld         = 1'b0;
        res_b_vld         = 1'b0;
        res_a             = '{faq_pkg::EV_NONE, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0};
        res_b             = '{faq_pkg::EV_NONE, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0};

        if (cmd_reg)
        begin
            armed_next        = 1'b0;
            motion_time_next  = 32'd0;
            first_impact_next = 32'd0;
            res_a_vld         = 1'b1;
            res_a = '{faq_pkg::EV_DISARM, 1'b1, fall_th_reg, 1'b0, immobile_reg, 1'b0};
        end
        else
        begin
            if (armed_reg)
            begin
                if (still > immobile_lim_reg)
                begin
                    if (!immobile_reg)
                    begin
                        i1        = 1'b1;
                        res_a_vld = 1'b1;
                        res_a = '{faq_pkg::EV_ALARM, 1'b0, 8'd0, 1'b1, 1'b1, 1'b0};
                    end
                end
                else if ((since_first > recovery_lim_reg) && (still < recent_lim_reg))
                begin
                    a1        = 1'b0;
                    i1        = 1'b0;
                    res_a_vld = 1'b1;
                    res_a = '{faq_pkg::EV_DISARM, 1'b1, fall_th_reg, 1'b0, 1'b0, 1'b0};
                end
            end
            armed_next    = a1;
            immobile_next = i1;
            if (impact)
            begin
                motion_time_next = now_reg;
                if (!a1)
                begin
                    armed_next        = 1'b1;
                    immobile_next     = 1'b0;
                    first_impact_next = now_reg;
                    res_b_vld         = 1'b1;
                    res_b = '{faq_pkg::EV_ARM, 1'b1, post_fall_th_reg, 1'b1, 1'b0, 1'b0};
                end
                else if (i1)
                begin
                    immobile_next = 1'b0;
                    res_b_vld     = 1'b1;
                    res_b = '{faq_pkg::EV_CANCEL, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0};
                end
            end
        end

        // mark the final result and move a lone second result to the front
        if (res_b_vld)
            res_b.last = 1'b1;
        else
            res_a.last = 1'b1;
        if (!res_a_vld)
            res_a = res_b;
    end

    assign push_n = push ? ((QPW+1)'(res_a_vld) + (QPW+1)'(res_b_vld)) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg        <= 1'b0;
            immobile_reg     <= 1'b0;
            motion_time_reg  <= 32'd0;
            first_impact_reg <= 32'd0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            count_reg        <= '0;
        end
        else
        begin
            if (push)
            begin
                armed_reg        <= armed_next;
                immobile_reg     <= immobile_next;
                motion_time_reg  <= motion_time_next;
                first_impact_reg <= first_impact_next;
                wr_ptr_reg       <= wr_ptr_reg + QPW'(push_n);
            end
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPW'(1);
            count_reg <= count_reg + push_n - (QPW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && (res_a_vld || res_b_vld))
            q_reg[wr_ptr_reg] <= res_a;
        if (push && res_a_vld && res_b_vld)
            q_reg[wr_ptr_reg + QPW'(1)] <= res_b;
    end

    assign out_valid       = (count_reg != '0);
    assign event_res       = q_reg[rd_ptr_reg].event_res;
    assign threshold_write = q_reg[rd_ptr_reg].threshold_write;
    assign threshold_value = q_reg[rd_ptr_reg].threshold_value;
    assign armed           = q_reg[rd_ptr_reg].armed;
    assign immobile        = q_reg[rd_ptr_reg].immobile;
    assign last            = q_reg[rd_ptr_reg].last;

endmodule
